### design/bdq_pkg.sv
// Package for the bounded deque with indexed read.
// Holds the transfer structs, the operation and status codes and field widths.
// No dependencies.
package bdq_pkg;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RD_INDEX = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RD_HEAD  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RD_TAIL  = 3'd6;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] element_value;
    logic [POS_W-1:0]   position;
  } bdq_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [SIZE_W-1:0]  size_after;
    logic [STAT_W-1:0]  status;
  } bdq_out_t;

  // Per-operation result from the pointer control, minus the read data.
  typedef struct packed {
    logic              rd;
    logic [SIZE_W-1:0] size_after;
    logic [STAT_W-1:0] status;
  } bdq_res_t;

endpackage

### design/bdq_mem.sv
// Element store: single-port synchronous RAM with a registered read.
// Depends on nothing beyond its parameters.
module bdq_mem #(
  parameter int CAPACITY = 256,
  parameter int ELEMENT_WIDTH = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [AW-1:0]            addr,
  input  logic [ELEMENT_WIDTH-1:0] wdata,
  output logic [ELEMENT_WIDTH-1:0] rdata
);

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/bdq_ctrl.sv
// Head pointer and count registers, operation decode and store addressing.
// Uses bdq_pkg.
module bdq_ctrl #(
  parameter int CAPACITY = 256,
  parameter int ELEMENT_WIDTH = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  bdq_pkg::bdq_in_t         item,
  output logic                     mem_we,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_addr,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata,
  output bdq_pkg::bdq_res_t        res
);
  import bdq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + POS_W;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] count_m1;
  logic          full, empty;
  logic [AW-1:0] idx;
  logic          wr, rd;
  logic [STAT_W-1:0] stat;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] lg);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, lg};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign count_m1 = count - 1'b1;

  always_comb begin
    head_next = head;
    count_next = count;
    wr = 1'b0;
    rd = 1'b0;
    stat = ST_DONE;
    mem_addr = '0;
    if (XW'(item.position) >= XW'(count)) begin
      idx = count_m1[AW-1:0];
    end else begin
      idx = AW'(item.position);
    end
    unique case (item.mode)
      MODE_INS_HEAD: begin
        if (full) begin
          stat = ST_FULL;
        end else begin
          head_next = (head == '0) ? AW'(CAPACITY - 1) : head - 1'b1;
          mem_addr = head_next;
          wr = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_INS_TAIL: begin
        if (full) begin
          stat = ST_FULL;
        end else begin
          mem_addr = slot(head, count[AW-1:0]);
          wr = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_REM_HEAD: begin
        if (empty) begin
          stat = ST_EMPTY;
        end else begin
          head_next = slot(head, AW'(1));
          count_next = count_m1;
        end
      end
      MODE_REM_TAIL: begin
        if (empty) begin
          stat = ST_EMPTY;
        end else begin
          count_next = count_m1;
        end
      end
      MODE_RD_INDEX, MODE_RD_HEAD, MODE_RD_TAIL: begin
        if (empty) begin
          stat = ST_EMPTY;
        end else begin
          rd = 1'b1;
          if (item.mode == MODE_RD_HEAD) begin
            mem_addr = head;
          end else if (item.mode == MODE_RD_TAIL) begin
            mem_addr = slot(head, count_m1[AW-1:0]);
          end else begin
            mem_addr = slot(head, idx);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we         = go && wr;
  assign mem_re         = go && rd;
  assign mem_wdata      = ELEMENT_WIDTH'(item.element_value);
  assign res.rd         = rd;
  assign res.size_after = SIZE_W'(count_next);
  assign res.status     = stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else if (go) begin
      head <= head_next;
      count <= count_next;
    end
  end

endmodule

### design/bounded_deque_with_index_read.sv
// Top level of the bounded deque with indexed read.
// Uses bdq_pkg, bdq_ctrl and bdq_mem.
//
//   channel | handshake           | payload
//   input   | in_valid / in_stall | in_item  (bdq_in_t)
//   output  | out_valid/out_stall | out_item (bdq_out_t)
//
// Insert, remove, no-op and empty-list read items give their result in the cycle after the transfer.
// Reads of a non-empty list pass through the pend register first, as the store's read port is registered.
// One item in flight at a time; input stalls during a store read or output stall.
// Reset clears head and count; store contents are undefined until written.
// A stalled result is held in the output register.
module bounded_deque_with_index_read #(
  parameter int CAPACITY = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdq_pkg::bdq_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output bdq_pkg::bdq_out_t out_item
);
  import bdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                     accept;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_addr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;
  bdq_res_t                 res;
  logic                     pend;
  bdq_res_t                 pend_res;

  assign in_stall = pend || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  bdq_ctrl #(.CAPACITY(CAPACITY), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst), .go(accept), .item(in_item),
    .mem_we(mem_we), .mem_re(mem_re), .mem_addr(mem_addr),
    .mem_wdata(mem_wdata), .res(res)
  );

  bdq_mem #(.CAPACITY(CAPACITY), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mem (
    .clk(clk), .we(mem_we), .re(mem_re), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      priority if (pend) begin
        pend <= 1'b0;
        out_valid <= 1'b1;
      end else if (accept && res.rd) begin
        pend <= 1'b1;
        out_valid <= 1'b0;
      end else if (accept) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_res <= res;
    end
    if (pend) begin
      out_item.read_value <= VALUE_W'(mem_rdata);
      out_item.size_after <= pend_res.size_after;
      out_item.status     <= pend_res.status;
    end else if (accept && !res.rd) begin
      out_item.read_value <= '0;
      out_item.size_after <= res.size_after;
      out_item.status     <= res.status;
    end
  end

endmodule

### design/bdq_check.sv
// Port-level checks for bounded_deque_with_index_read, and the bind that attaches them.
// Uses bdq_pkg.
module bdq_check (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input bdq_pkg::bdq_in_t  in_item,
  input logic              out_valid,
  input logic              out_stall,
  input bdq_pkg::bdq_out_t out_item
);
  import bdq_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input transfer changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall) || $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transfer");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_EMPTY |-> out_item.size_after == '0
      && out_item.read_value == '0)
    else $error("empty status with nonzero size or data");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_FULL |-> out_item.read_value == '0)
    else $error("dropped insert returned data");

endmodule

bind bounded_deque_with_index_read bdq_check u_bdq_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
